// File: design/cmc_pkg.sv
// Shared types, widths and reset values for the chroma match centroid block.
// No dependencies; every other file in the block refers to this package.
`timescale 1ns / 1ps

package cmc_pkg;

  localparam int COORD_BITS   = 12;
  localparam int CHROMA_BITS  = 8;
  localparam int THR_BITS     = 17;
  localparam int SPACING_BITS = 8;
  localparam int SUM_BITS     = 37;
  localparam int CNT_BITS     = 25;
  localparam int HALF_BITS    = SPACING_BITS - 1;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = (THR_BITS > COORD_BITS) ? THR_BITS : COORD_BITS;

  // divider widths: the divisor starts shifted up by COORD_BITS-1 places
  localparam int DSR_BITS  = CNT_BITS + COORD_BITS - 1;
  localparam int CMP_BITS  = SUM_BITS + COORD_BITS;
  localparam int STEP_BITS = $clog2(COORD_BITS);

  localparam logic [CHROMA_BITS-1:0]  RST_TARGET_U  = CHROMA_BITS'(135);
  localparam logic [CHROMA_BITS-1:0]  RST_TARGET_V  = CHROMA_BITS'(64);
  localparam logic [THR_BITS-1:0]     RST_THRESHOLD = THR_BITS'(1000);
  localparam logic [SPACING_BITS-1:0] RST_SPACING   = SPACING_BITS'(8);
  localparam logic [COORD_BITS-1:0]   RST_WIDTH     = COORD_BITS'(1280);
  localparam logic [COORD_BITS-1:0]   RST_HEIGHT    = COORD_BITS'(720);
  localparam logic [COORD_BITS-1:0]   RST_HALF      = COORD_BITS'(RST_SPACING >> 1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TARGET_U,
    CFG_TARGET_V,
    CFG_THRESHOLD,
    CFG_SPACING,
    CFG_WIDTH,
    CFG_HEIGHT
  } cfg_reg_e;

  typedef struct packed {
    logic [CHROMA_BITS-1:0] chroma_u;
    logic [CHROMA_BITS-1:0] chroma_v;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] sample_x;
    logic [COORD_BITS-1:0] sample_y;
    logic                  is_match;
    logic                  frame_done;
    logic [COORD_BITS-1:0] mean_x;
    logic [COORD_BITS-1:0] mean_y;
    logic [CNT_BITS-1:0]   match_count;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic load_item;
    logic div_start;
    logic load_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic div_done;
  } dp_status_t;

endpackage

// File: design/cmc_div.sv
// Iterative restoring divider for the centroid: one quotient bit per cycle.
// Depends on cmc_pkg. Quotient is known to fit COORD_BITS (mean of coordinates).
`timescale 1ns / 1ps

module cmc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cmc_pkg::SUM_BITS-1:0]  dividend_i,
  input  logic [cmc_pkg::CNT_BITS-1:0]  divisor_i,
  output logic [cmc_pkg::COORD_BITS-1:0] quotient_o,
  output logic                          done_o
);

  logic [cmc_pkg::SUM_BITS-1:0]   rem_q, rem_d;
  logic [cmc_pkg::DSR_BITS-1:0]   dsr_q;
  logic [cmc_pkg::COORD_BITS-1:0] quo_q;
  logic [cmc_pkg::STEP_BITS-1:0]  step_q;
  logic                           busy_q;
  logic                           done_q;
  logic [cmc_pkg::CMP_BITS-1:0]   rem_ext, dsr_ext, diff;
  logic                           ge;

  assign rem_ext = cmc_pkg::CMP_BITS'(rem_q);
  assign dsr_ext = cmc_pkg::CMP_BITS'(dsr_q);
  assign ge      = rem_ext >= dsr_ext;
  assign diff    = rem_ext - dsr_ext;
  assign rem_d   = ge ? diff[cmc_pkg::SUM_BITS-1:0] : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && !start_i && (step_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= cmc_pkg::STEP_BITS'(cmc_pkg::COORD_BITS - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      dsr_q <= {divisor_i, {(cmc_pkg::COORD_BITS - 1){1'b0}}};
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dsr_q <= dsr_q >> 1;
      quo_q <= {quo_q[cmc_pkg::COORD_BITS-2:0], ge};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// File: design/cmc_datapath.sv
// Datapath: configuration registers, grid walker, chroma distance test,
// accumulators, centroid dividers and the output register. Depends on cmc_pkg, cmc_div.
`timescale 1ns / 1ps

module cmc_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cmc_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [cmc_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  cmc_pkg::in_item_t                 in_data_i,
  input  cmc_pkg::ctrl_cmd_t                cmd_i,
  output cmc_pkg::dp_status_t               status_o,
  output cmc_pkg::out_item_t                out_data_o
);

  localparam int XB = cmc_pkg::COORD_BITS + 1;

  logic [cmc_pkg::CHROMA_BITS-1:0]  tu_q, tv_q;
  logic [cmc_pkg::THR_BITS-1:0]     thr_q;
  logic [cmc_pkg::SPACING_BITS-1:0] sp_q;
  logic [cmc_pkg::COORD_BITS-1:0]   fw_q, fh_q;
  logic [cmc_pkg::COORD_BITS-1:0]   grid_x_q, grid_y_q;
  logic [cmc_pkg::SUM_BITS-1:0]     sum_x_q, sum_y_q;
  logic [cmc_pkg::CNT_BITS-1:0]     hit_q;

  cmc_pkg::out_item_t out_q, pend_q, res, fin;

  logic [cmc_pkg::SPACING_BITS-1:0] sp_eff, sp_new, sp_new_eff;
  logic [cmc_pkg::HALF_BITS-1:0]    half, half_new;
  logic [cmc_pkg::COORD_BITS-1:0]   half_c, half_new_c, sp_c, lim_x, lim_y;
  logic [XB-1:0]                    next_x, next_y;
  logic                             empty, last_col, last_row, frame_end;
  logic                             geo_wr;
  logic signed [cmc_pkg::CHROMA_BITS:0]     du, dv;
  logic signed [2*cmc_pkg::CHROMA_BITS+1:0] du_w, dv_w;
  logic [2*cmc_pkg::CHROMA_BITS+1:0]        du_sq, dv_sq, sq_dist;
  logic                             match;
  logic [cmc_pkg::SUM_BITS-1:0]     sum_x_nx, sum_y_nx;
  logic [cmc_pkg::CNT_BITS-1:0]     hit_nx;
  logic [cmc_pkg::COORD_BITS-1:0]   quo_x, quo_y;
  logic                             done_x, done_y;

  // a spacing of zero behaves as one
  assign sp_eff = (sp_q == '0) ? cmc_pkg::SPACING_BITS'(1) : sp_q;
  assign half   = sp_eff[cmc_pkg::SPACING_BITS-1:1];
  assign half_c = cmc_pkg::COORD_BITS'(half);
  assign sp_c   = cmc_pkg::COORD_BITS'(sp_eff);

  // no grid point when 2*half exceeds the frame size
  assign empty = ({half_c, 1'b0} > {1'b0, fw_q}) || ({half_c, 1'b0} > {1'b0, fh_q});
  assign lim_x = fw_q - half_c;
  assign lim_y = fh_q - half_c;
  assign next_x = {1'b0, grid_x_q} + {1'b0, sp_c};
  assign next_y = {1'b0, grid_y_q} + {1'b0, sp_c};
  assign last_col  = next_x > {1'b0, lim_x};
  assign last_row  = next_y > {1'b0, lim_y};
  assign frame_end = !empty && last_col && last_row;

  assign du      = $signed({1'b0, in_data_i.chroma_u}) - $signed({1'b0, tu_q});
  assign dv      = $signed({1'b0, in_data_i.chroma_v}) - $signed({1'b0, tv_q});
  assign du_w    = (2*cmc_pkg::CHROMA_BITS+2)'(du);
  assign dv_w    = (2*cmc_pkg::CHROMA_BITS+2)'(dv);
  assign du_sq   = du_w * du_w;
  assign dv_sq   = dv_w * dv_w;
  assign sq_dist = du_sq + dv_sq;
  assign match   = sq_dist < (2*cmc_pkg::CHROMA_BITS+2)'(thr_q);

  assign sum_x_nx = match ? sum_x_q + cmc_pkg::SUM_BITS'(grid_x_q) : sum_x_q;
  assign sum_y_nx = match ? sum_y_q + cmc_pkg::SUM_BITS'(grid_y_q) : sum_y_q;
  assign hit_nx   = match ? hit_q + 1'b1 : hit_q;

  always_comb begin
    res = '0;
    if (empty) begin
      res.sample_x   = half_c;
      res.sample_y   = half_c;
      res.frame_done = 1'b1;
    end else begin
      res.sample_x   = grid_x_q;
      res.sample_y   = grid_y_q;
      res.is_match   = match;
      res.frame_done = frame_end;
      if (frame_end) begin
        res.match_count = hit_nx;
      end
    end
  end

  // geometry writes restart the frame with the half step of the new spacing
  assign geo_wr = cfg_we_i && ((cfg_idx_i == cmc_pkg::CFG_SPACING) ||
                               (cfg_idx_i == cmc_pkg::CFG_WIDTH) ||
                               (cfg_idx_i == cmc_pkg::CFG_HEIGHT));
  assign sp_new = (cfg_idx_i == cmc_pkg::CFG_SPACING) ?
                  cfg_wdata_i[cmc_pkg::SPACING_BITS-1:0] : sp_q;
  assign sp_new_eff = (sp_new == '0) ? cmc_pkg::SPACING_BITS'(1) : sp_new;
  assign half_new   = sp_new_eff[cmc_pkg::SPACING_BITS-1:1];
  assign half_new_c = cmc_pkg::COORD_BITS'(half_new);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tu_q     <= cmc_pkg::RST_TARGET_U;
      tv_q     <= cmc_pkg::RST_TARGET_V;
      thr_q    <= cmc_pkg::RST_THRESHOLD;
      sp_q     <= cmc_pkg::RST_SPACING;
      fw_q     <= cmc_pkg::RST_WIDTH;
      fh_q     <= cmc_pkg::RST_HEIGHT;
      grid_x_q <= cmc_pkg::RST_HALF;
      grid_y_q <= cmc_pkg::RST_HALF;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      hit_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cmc_pkg::cfg_reg_e'(cfg_idx_i))
          cmc_pkg::CFG_TARGET_U:  tu_q  <= cfg_wdata_i[cmc_pkg::CHROMA_BITS-1:0];
          cmc_pkg::CFG_TARGET_V:  tv_q  <= cfg_wdata_i[cmc_pkg::CHROMA_BITS-1:0];
          cmc_pkg::CFG_THRESHOLD: thr_q <= cfg_wdata_i[cmc_pkg::THR_BITS-1:0];
          cmc_pkg::CFG_SPACING:   sp_q  <= cfg_wdata_i[cmc_pkg::SPACING_BITS-1:0];
          cmc_pkg::CFG_WIDTH:     fw_q  <= cfg_wdata_i[cmc_pkg::COORD_BITS-1:0];
          cmc_pkg::CFG_HEIGHT:    fh_q  <= cfg_wdata_i[cmc_pkg::COORD_BITS-1:0];
          default: ;
        endcase
      end
      if (geo_wr) begin
        grid_x_q <= half_new_c;
        grid_y_q <= half_new_c;
        sum_x_q  <= '0;
        sum_y_q  <= '0;
        hit_q    <= '0;
      end else if (cmd_i.accept) begin
        if (empty || frame_end) begin
          grid_x_q <= half_c;
          grid_y_q <= half_c;
          sum_x_q  <= '0;
          sum_y_q  <= '0;
          hit_q    <= '0;
        end else begin
          sum_x_q <= sum_x_nx;
          sum_y_q <= sum_y_nx;
          hit_q   <= hit_nx;
          if (last_col) begin
            grid_x_q <= half_c;
            grid_y_q <= next_y[cmc_pkg::COORD_BITS-1:0];
          end else begin
            grid_x_q <= next_x[cmc_pkg::COORD_BITS-1:0];
          end
        end
      end
    end
  end

  cmc_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_x_nx),
    .divisor_i  (hit_nx),
    .quotient_o (quo_x),
    .done_o     (done_x)
  );

  cmc_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_y_nx),
    .divisor_i  (hit_nx),
    .quotient_o (quo_y),
    .done_o     (done_y)
  );

  // no matches: centroid stays at zero
  always_comb begin
    fin = pend_q;
    if (pend_q.match_count != '0) begin
      fin.mean_x = quo_x;
      fin.mean_y = quo_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      pend_q <= res;
    end
    if (cmd_i.load_item) begin
      out_q <= res;
    end else if (cmd_i.load_done) begin
      out_q <= fin;
    end
  end

  assign status_o.frame_end = frame_end;
  assign status_o.div_done  = done_x && done_y;
  assign out_data_o         = out_q;

endmodule

// File: design/cmc_ctrl.sv
// Controller: sequences item acceptance, the end-of-frame divide and the
// output register valid flag. Depends on cmc_pkg.
`timescale 1ns / 1ps

module cmc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_stall_i,
  input  cmc_pkg::dp_status_t status_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output cmc_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_HOLD
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_RUN: begin
        in_stall_o      = !out_free;
        cmd_o.accept    = in_valid_i && out_free;
        cmd_o.load_item = cmd_o.accept && !status_i.frame_end;
        cmd_o.div_start = cmd_o.accept && status_i.frame_end;
      end
      ST_DIV: begin
        cmd_o.load_done = status_i.div_done && out_free;
      end
      ST_HOLD: begin
        cmd_o.load_done = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_RUN: begin
          if (cmd_o.div_start) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (status_i.div_done) begin
            state_q <= out_free ? ST_RUN : ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state_q <= ST_RUN;
          end
        end
        default: state_q <= ST_RUN;
      endcase
      if (cmd_o.load_item || cmd_o.load_done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: design/chroma_match_centroid_unit.sv
// Top level of the chroma match centroid block: controller plus datapath.
// Depends on cmc_pkg, cmc_ctrl, cmc_datapath (and through it cmc_div).
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------------
//   input   | in_valid_i / in_stall_o | in_data_i  (cmc_pkg::in_item_t)
//   output  | out_valid_o/out_stall_i | out_data_o (cmc_pkg::out_item_t)
//   config  | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// An ordinary grid point's result is registered at the accepting edge, and a
// new item can be taken every cycle while the output register is free.
// The last grid point of a frame starts the bit-per-cycle centroid dividers
// on acceptance; its result is registered once both are done and the output
// register is free; input is stalled meanwhile.
// Reset restores register defaults and starts a new frame; nothing to sweep.
// A stalled output holds its item; outside the divide, input is stalled only
// while the output register holds a stalled item.
`timescale 1ns / 1ps

module chroma_match_centroid_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  cmc_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output cmc_pkg::out_item_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [cmc_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [cmc_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i
);

  cmc_pkg::ctrl_cmd_t  cmd;
  cmc_pkg::dp_status_t status;

  cmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  cmc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

// File: design/cmc_checker.sv
// Port-level checks for chroma_match_centroid_unit, attached by bind.
// Depends on cmc_pkg.
`timescale 1ns / 1ps

module cmc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input cmc_pkg::out_item_t out_data_o
);

  // frame summary fields are zero on every point but the last
  a_summary_zero_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.frame_done |->
      out_data_o.mean_x == '0 && out_data_o.mean_y == '0 &&
      out_data_o.match_count == '0)
    else $error("frame summary set on a mid-frame item");

  a_no_hits_no_centroid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_done && out_data_o.match_count == '0 |->
      out_data_o.mean_x == '0 && out_data_o.mean_y == '0)
    else $error("centroid reported with no matches");

  // a matching last point is itself counted
  a_last_hit_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_done && out_data_o.is_match |->
      out_data_o.match_count != '0)
    else $error("matching last point missing from count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output item changed");

endmodule

bind chroma_match_centroid_unit cmc_checker u_cmc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
